### rtl/dac_pkg.sv
// Shared types and constants for the decimal accumulator CPU core.
package dac_pkg;

    localparam int MEM_WORDS_DEF = 100;
    localparam int WORD_BITS     = 32;
    localparam int PC_BITS       = 7;
    localparam int STATUS_BITS   = 3;

    // Decode of non-negative words below DEC_LIMIT: q = (w * RECIP) >> RECIP_SHIFT
    localparam int DEC_LIMIT   = 4400;
    localparam int RECIP       = 5243;
    localparam int RECIP_SHIFT = 19;

    // instruction opcodes (word / 100)
    localparam logic [5:0] OPC_READ   = 6'd10;
    localparam logic [5:0] OPC_WRITE  = 6'd11;
    localparam logic [5:0] OPC_LOAD   = 6'd20;
    localparam logic [5:0] OPC_STORE  = 6'd21;
    localparam logic [5:0] OPC_ADD    = 6'd30;
    localparam logic [5:0] OPC_SUB    = 6'd31;
    localparam logic [5:0] OPC_DIV    = 6'd32;
    localparam logic [5:0] OPC_MUL    = 6'd33;
    localparam logic [5:0] OPC_BR     = 6'd40;
    localparam logic [5:0] OPC_BRNEG  = 6'd41;
    localparam logic [5:0] OPC_BRZERO = 6'd42;
    localparam logic [5:0] OPC_HALT   = 6'd43;

    typedef enum logic [1:0] {
        OP_LOAD_WORD = 2'd0,
        OP_EXEC      = 2'd1,
        OP_PEEK      = 2'd2,
        OP_RESTART   = 2'd3
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK       = 3'd0,
        ST_HALTED   = 3'd1,
        ST_PAST_END = 3'd2,
        ST_BAD_OPC  = 3'd3,
        ST_DIV_ZERO = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        IC_READ, IC_WRITE, IC_LOAD, IC_STORE, IC_ADD, IC_SUB, IC_DIV, IC_MUL,
        IC_BR, IC_BRNEG, IC_BRZERO, IC_HALT, IC_BAD
    } icode_t;

    typedef struct packed {
        logic take_in;
        logic wr_in;
        logic rd_addr;
        logic rd_pc;
        logic rd_ix;
        logic peek_cap;
        logic restart;
        logic stop_chk;
        logic exec;
        logic div_apply;
        logic out_load;
    } dac_cmd_t;

    typedef struct packed {
        op_t  op;
        logic is_stopped;
        logic div_go;
        logic div_done;
    } dac_sts_t;

endpackage

### rtl/decimal_accumulator_cpu_core.sv
// Top level of the decimal accumulator CPU core.
//
//  channel  ports                               role
//  s_       s_valid s_ready s_op s_address       input transaction
//           s_data_word
//  m_       m_valid m_ready m_peek_word          result transaction
//           m_next_pc m_acc_value m_out_valid m_out_word m_status
//
// One transaction at a time. Load word, restart and execute on a stopped
// machine pass through dispatch and finish, peek adds a capture step; an executed
// instruction goes through store read of the word, store read of the operand, execute.
// A divide then waits for the radix-2 divider before finishing.
// Store entries read as zero after reset through per-entry valid bits; no
// clearing pass. A stalled result holds the output register, and the next
// transaction is taken while it waits; only the following result then waits.
module decimal_accumulator_cpu_core #(
    parameter int MEM_WORDS = dac_pkg::MEM_WORDS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_op,
    input  logic [dac_pkg::PC_BITS-1:0]          s_address,
    input  logic signed [dac_pkg::WORD_BITS-1:0] s_data_word,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [dac_pkg::WORD_BITS-1:0] m_peek_word,
    output logic [dac_pkg::PC_BITS-1:0]          m_next_pc,
    output logic signed [dac_pkg::WORD_BITS-1:0] m_acc_value,
    output logic                                 m_out_valid,
    output logic signed [dac_pkg::WORD_BITS-1:0] m_out_word,
    output logic [dac_pkg::STATUS_BITS-1:0]      m_status
);

    dac_pkg::dac_cmd_t cmd;
    dac_pkg::dac_sts_t sts;

    dac_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    dac_datapath #(
        .MEM_WORDS(MEM_WORDS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_op        (s_op),
        .s_address   (s_address),
        .s_data_word (s_data_word),
        .m_peek_word (m_peek_word),
        .m_next_pc   (m_next_pc),
        .m_acc_value (m_acc_value),
        .m_out_valid (m_out_valid),
        .m_out_word  (m_out_word),
        .m_status    (m_status)
    );

endmodule

### rtl/dac_div.sv
// Radix-2 restoring signed divider, one quotient bit per cycle.
module dac_div #(
    parameter int W = dac_pkg::WORD_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);

    localparam int CNT_BITS = $clog2(W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [W:0]          rem_reg, rem_next;
    logic [W-1:0]        quo_reg, quo_next;
    logic [W-1:0]        dsr_reg, dsr_next;
    logic                neg_reg, neg_next;
    logic [W-1:0]        q_reg, q_next;

    logic [W:0] shifted;
    logic [W:0] diff;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        q_next    = q_reg;
        shifted   = {rem_reg[W-1:0], quo_reg[W-1]};
        diff      = shifted - {1'b0, dsr_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend[W-1] ? (~dividend + W'(1)) : dividend;
            dsr_next  = divisor[W-1] ? (~divisor + W'(1)) : divisor;
            neg_next  = dividend[W-1] ^ divisor[W-1];
        end else if (busy_reg) begin
            if (!diff[W]) begin
                rem_next = diff;
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                q_next    = neg_reg ? (~quo_next + W'(1)) : quo_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

### rtl/dac_datapath.sv
// Datapath: main store, accumulator, counter, decode, execute and result registers.
module dac_datapath #(
    parameter int MEM_WORDS = dac_pkg::MEM_WORDS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  dac_pkg::dac_cmd_t                      cmd,
    output dac_pkg::dac_sts_t                      sts,
    input  logic [1:0]                             s_op,
    input  logic [dac_pkg::PC_BITS-1:0]            s_address,
    input  logic signed [dac_pkg::WORD_BITS-1:0]   s_data_word,
    output logic signed [dac_pkg::WORD_BITS-1:0]   m_peek_word,
    output logic [dac_pkg::PC_BITS-1:0]            m_next_pc,
    output logic signed [dac_pkg::WORD_BITS-1:0]   m_acc_value,
    output logic                                   m_out_valid,
    output logic signed [dac_pkg::WORD_BITS-1:0]   m_out_word,
    output logic [dac_pkg::STATUS_BITS-1:0]        m_status
);

    localparam int W      = dac_pkg::WORD_BITS;
    localparam int PW     = dac_pkg::PC_BITS;
    localparam int ADDR_W = $clog2(MEM_WORDS);
    localparam logic [PW-1:0] PC_END = PW'(MEM_WORDS);

    // main store: valid bits stand in for the zero reset
    logic [W-1:0]         mem [MEM_WORDS];
    logic [MEM_WORDS-1:0] vld_reg;
    logic [W-1:0]         mem_q_reg;
    logic                 vld_q_reg;
    logic [W-1:0]         rd_word;

    logic                 wr_en;
    logic [PW-1:0]        wr_addr;
    logic [W-1:0]         wr_data;
    logic                 rd_en;
    logic [PW-1:0]        rd_addr;

    // state and transaction registers
    logic [1:0]           op_reg;
    logic [PW-1:0]        addr_reg;
    logic [W-1:0]         data_reg;
    logic [W-1:0]         acc_reg, acc_next;
    logic [PW-1:0]        pc_reg, pc_next;
    logic                 stopped_reg, stopped_next;
    dac_pkg::icode_t      code_reg;
    logic                 ok_reg;
    logic [PW-1:0]        ix_reg;

    logic [W-1:0]                   res_peek_reg, res_peek_next;
    logic                           res_ov_reg, res_ov_next;
    logic [W-1:0]                   res_ow_reg, res_ow_next;
    dac_pkg::status_t               res_st_reg, res_st_next;

    logic [W-1:0]                   out_peek_reg;
    logic [PW-1:0]                  out_pc_reg;
    logic [W-1:0]                   out_acc_reg;
    logic                           out_ov_reg;
    logic [W-1:0]                   out_ow_reg;
    logic [dac_pkg::STATUS_BITS-1:0] out_st_reg;

    // decode
    logic [12:0]          dec_v;
    logic [25:0]          dec_prod;
    logic [5:0]           dec_q;
    logic [12:0]          dec_qx;
    logic [PW-1:0]        dec_r;
    logic                 dec_small;
    logic                 dec_ok;
    logic [PW-1:0]        dec_ix;
    dac_pkg::icode_t      dec_code;

    logic [W-1:0]         mul_lo;
    logic                 taken;
    logic [PW-1:0]        npc;
    logic                 div_done;
    logic [W-1:0]         div_q;

    assign rd_word = vld_q_reg ? mem_q_reg : '0;

    always_comb begin
        dec_v     = rd_word[12:0];
        dec_prod  = {13'd0, dec_v} * 26'(dac_pkg::RECIP);
        dec_q     = dec_prod[dac_pkg::RECIP_SHIFT +: 6];
        dec_qx    = 13'({7'd0, dec_q} * 13'd100);
        dec_r     = PW'(dec_v - dec_qx);
        dec_small = !rd_word[W-1] && (rd_word < W'(dac_pkg::DEC_LIMIT));
        dec_ok    = dec_r < PC_END;
        dec_ix    = dec_ok ? dec_r : '0;
        case (dec_q)
            dac_pkg::OPC_READ:   dec_code = dac_pkg::IC_READ;
            dac_pkg::OPC_WRITE:  dec_code = dac_pkg::IC_WRITE;
            dac_pkg::OPC_LOAD:   dec_code = dac_pkg::IC_LOAD;
            dac_pkg::OPC_STORE:  dec_code = dac_pkg::IC_STORE;
            dac_pkg::OPC_ADD:    dec_code = dac_pkg::IC_ADD;
            dac_pkg::OPC_SUB:    dec_code = dac_pkg::IC_SUB;
            dac_pkg::OPC_DIV:    dec_code = dac_pkg::IC_DIV;
            dac_pkg::OPC_MUL:    dec_code = dac_pkg::IC_MUL;
            dac_pkg::OPC_BR:     dec_code = dac_pkg::IC_BR;
            dac_pkg::OPC_BRNEG:  dec_code = dac_pkg::IC_BRNEG;
            dac_pkg::OPC_BRZERO: dec_code = dac_pkg::IC_BRZERO;
            dac_pkg::OPC_HALT:   dec_code = dac_pkg::IC_HALT;
            default:             dec_code = dac_pkg::IC_BAD;
        endcase
        // negative words and words of 4400 and up never carry a valid opcode
        if (!dec_small) begin
            dec_code = dac_pkg::IC_BAD;
        end
    end

    // memory port selection
    always_comb begin
        rd_en   = cmd.rd_addr | cmd.rd_pc | cmd.rd_ix;
        rd_addr = cmd.rd_pc ? pc_reg : (cmd.rd_ix ? dec_ix : addr_reg);
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = data_reg;
        if (cmd.wr_in && addr_reg < PC_END) begin
            wr_en = 1'b1;
        end
        if (cmd.exec && ok_reg) begin
            wr_addr = ix_reg;
            if (code_reg == dac_pkg::IC_READ) begin
                wr_en = 1'b1;
            end else if (code_reg == dac_pkg::IC_STORE) begin
                wr_en   = 1'b1;
                wr_data = acc_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr[ADDR_W-1:0]] <= wr_data;
        end
        if (rd_en) begin
            mem_q_reg <= mem[rd_addr[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr[ADDR_W-1:0]] <= 1'b1;
            end
            if (rd_en) begin
                vld_q_reg <= vld_reg[rd_addr[ADDR_W-1:0]];
            end
        end
    end

    assign mul_lo = acc_reg * rd_word;

    always_comb begin
        acc_next      = acc_reg;
        pc_next       = pc_reg;
        stopped_next  = stopped_reg;
        res_peek_next = res_peek_reg;
        res_ov_next   = res_ov_reg;
        res_ow_next   = res_ow_reg;
        res_st_next   = res_st_reg;
        taken         = 1'b0;
        npc           = pc_reg + PW'(1);
        if (cmd.take_in) begin
            res_peek_next = '0;
            res_ov_next   = 1'b0;
            res_ow_next   = '0;
            res_st_next   = dac_pkg::ST_OK;
        end
        if (cmd.peek_cap && addr_reg < PC_END) begin
            res_peek_next = rd_word;
        end
        if (cmd.restart) begin
            pc_next      = '0;
            stopped_next = 1'b0;
        end
        if (cmd.stop_chk) begin
            stopped_next = 1'b1;
            res_st_next  = (pc_reg >= PC_END) ? dac_pkg::ST_PAST_END : dac_pkg::ST_HALTED;
        end
        if (cmd.exec) begin
            case (code_reg)
                dac_pkg::IC_WRITE: begin
                    if (ok_reg) begin
                        res_ov_next = 1'b1;
                        res_ow_next = rd_word;
                    end
                end
                dac_pkg::IC_LOAD:   if (ok_reg) acc_next = rd_word;
                dac_pkg::IC_ADD:    if (ok_reg) acc_next = acc_reg + rd_word;
                dac_pkg::IC_SUB:    if (ok_reg) acc_next = acc_reg - rd_word;
                dac_pkg::IC_MUL:    if (ok_reg) acc_next = mul_lo;
                dac_pkg::IC_DIV: begin
                    if (ok_reg && rd_word == '0) begin
                        acc_next    = '0;
                        res_st_next = dac_pkg::ST_DIV_ZERO;
                    end
                end
                dac_pkg::IC_BR:     taken = ok_reg;
                dac_pkg::IC_BRNEG:  taken = ok_reg && acc_reg[W-1];
                dac_pkg::IC_BRZERO: taken = ok_reg && (acc_reg == '0);
                dac_pkg::IC_BAD:    res_st_next = dac_pkg::ST_BAD_OPC;
                default: ;
            endcase
            if (taken) begin
                npc = ix_reg;
            end
            if (code_reg == dac_pkg::IC_HALT) begin
                stopped_next = 1'b1;
                res_st_next  = dac_pkg::ST_HALTED;
            end else if (npc >= PC_END) begin
                pc_next      = PC_END;
                stopped_next = 1'b1;
                if (res_st_next == dac_pkg::ST_OK) begin
                    res_st_next = dac_pkg::ST_PAST_END;
                end
            end else begin
                pc_next = npc;
            end
        end
        if (cmd.div_apply) begin
            acc_next = div_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            pc_reg      <= '0;
            stopped_reg <= 1'b0;
        end else begin
            acc_reg     <= acc_next;
            pc_reg      <= pc_next;
            stopped_reg <= stopped_next;
        end
        res_peek_reg <= res_peek_next;
        res_ov_reg   <= res_ov_next;
        res_ow_reg   <= res_ow_next;
        res_st_reg   <= res_st_next;
        if (cmd.take_in) begin
            op_reg   <= s_op;
            addr_reg <= s_address;
            data_reg <= s_data_word;
        end
        if (cmd.rd_ix) begin
            code_reg <= dec_code;
            ok_reg   <= dec_ok;
            ix_reg   <= dec_ix;
        end
        if (cmd.out_load) begin
            out_peek_reg <= res_peek_reg;
            out_pc_reg   <= pc_reg;
            out_acc_reg  <= acc_reg;
            out_ov_reg   <= res_ov_reg;
            out_ow_reg   <= res_ow_reg;
            out_st_reg   <= res_st_reg;
        end
    end

    dac_div #(
        .W(W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sts.div_go && cmd.exec),
        .dividend (acc_reg),
        .divisor  (rd_word),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        sts.op         = dac_pkg::op_t'(op_reg);
        sts.is_stopped = stopped_reg || (pc_reg >= PC_END);
        sts.div_go     = (code_reg == dac_pkg::IC_DIV) && ok_reg && (rd_word != '0);
        sts.div_done   = div_done;
    end

    assign m_peek_word = out_peek_reg;
    assign m_next_pc   = out_pc_reg;
    assign m_acc_value = out_acc_reg;
    assign m_out_valid = out_ov_reg;
    assign m_out_word  = out_ow_reg;
    assign m_status    = out_st_reg;

endmodule

### rtl/dac_ctrl.sv
// Controller: sequences one transaction through the datapath.
module dac_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output dac_pkg::dac_cmd_t cmd,
    input  dac_pkg::dac_sts_t sts
);

    typedef enum logic [2:0] {
        S_IDLE, S_DISPATCH, S_PEEK, S_DECODE, S_EXEC, S_DIV, S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.take_in = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (sts.op)
                    dac_pkg::OP_LOAD_WORD: begin
                        cmd.wr_in  = 1'b1;
                        state_next = S_FINISH;
                    end
                    dac_pkg::OP_PEEK: begin
                        cmd.rd_addr = 1'b1;
                        state_next  = S_PEEK;
                    end
                    dac_pkg::OP_RESTART: begin
                        cmd.restart = 1'b1;
                        state_next  = S_FINISH;
                    end
                    dac_pkg::OP_EXEC: begin
                        if (sts.is_stopped) begin
                            cmd.stop_chk = 1'b1;
                            state_next   = S_FINISH;
                        end else begin
                            cmd.rd_pc  = 1'b1;
                            state_next = S_DECODE;
                        end
                    end
                    default: state_next = S_FINISH;
                endcase
            end
            S_PEEK: begin
                cmd.peek_cap = 1'b1;
                state_next   = S_FINISH;
            end
            S_DECODE: begin
                cmd.rd_ix  = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = sts.div_go ? S_DIV : S_FINISH;
            end
            S_DIV: begin
                if (sts.div_done) begin
                    cmd.div_apply = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction taken while one is in flight");

    a_div_to_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) && sts.div_done |=> (state_reg == S_FINISH))
        else $error("divider completion not applied");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result presented outside finish state");

endmodule

### tb/sv/decimal_accumulator_cpu_core_test.sv
// Self-checking testbench for the decimal accumulator CPU core.
`timescale 1ns / 1ps

module decimal_accumulator_cpu_core_test;

    localparam int MEM   = 100;
    localparam int NRAND = 600;

    typedef struct packed {
        logic [31:0]      peek_word;
        logic [6:0]       next_pc;
        logic [31:0]      acc_value;
        logic             out_valid;
        logic [31:0]      out_word;
        dac_pkg::status_t status;
    } cpu_result_t;

    typedef struct packed {
        dac_pkg::op_t op;
        logic [6:0]   addr;
        logic [31:0]  data;
        logic         fixed;
        cpu_result_t  want;
    } step_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_op = 2'd0;
    logic [6:0]  s_address = 7'd0;
    logic signed [31:0] s_data_word = 32'sd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [31:0] m_peek_word;
    logic [6:0]  m_next_pc;
    logic signed [31:0] m_acc_value;
    logic        m_out_valid;
    logic signed [31:0] m_out_word;
    logic [2:0]  m_status;

    decimal_accumulator_cpu_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op),
        .s_address(s_address), .s_data_word(s_data_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_peek_word(m_peek_word),
        .m_next_pc(m_next_pc), .m_acc_value(m_acc_value),
        .m_out_valid(m_out_valid), .m_out_word(m_out_word), .m_status(m_status)
    );

    always #6 aclk = ~aclk;

    // mirror of the machine state
    logic [31:0] store_img [MEM];
    logic [31:0] acc_img;
    logic [6:0]  pc_img;
    logic        halted_img;

    cpu_result_t pending_q[$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    function automatic logic [31:0] magnitude(logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    task automatic run_machine(input dac_pkg::op_t op, input logic [6:0] addr,
                               input logic [31:0] data, output cpu_result_t r);
        int          w, opc, opd;
        logic [31:0] m, q;
        int          npc;
        r = '0;
        r.status = dac_pkg::ST_OK;
        case (op)
            dac_pkg::OP_LOAD_WORD: if (addr < MEM) store_img[addr] = data;
            dac_pkg::OP_PEEK:      if (addr < MEM) r.peek_word = store_img[addr];
            dac_pkg::OP_RESTART: begin
                pc_img = 7'd0;
                halted_img = 1'b0;
            end
            default: begin
                if (halted_img || pc_img >= MEM) begin
                    halted_img = 1'b1;
                    r.status = (pc_img >= MEM) ? dac_pkg::ST_PAST_END : dac_pkg::ST_HALTED;
                end else begin
                    w = $signed(store_img[pc_img]);
                    opc = w / 100;
                    opd = w % 100;
                    // negative words never decode to a valid opcode
                    m = (opd >= 0) ? store_img[opd] : 32'd0;
                    npc = pc_img + 1;
                    case (opc)
                        dac_pkg::OPC_READ:   store_img[opd] = data;
                        dac_pkg::OPC_WRITE: begin
                            r.out_valid = 1'b1;
                            r.out_word = m;
                        end
                        dac_pkg::OPC_LOAD:   acc_img = m;
                        dac_pkg::OPC_STORE:  store_img[opd] = acc_img;
                        dac_pkg::OPC_ADD:    acc_img = acc_img + m;
                        dac_pkg::OPC_SUB:    acc_img = acc_img - m;
                        dac_pkg::OPC_DIV: begin
                            if (m == 0) begin
                                acc_img = 32'd0;
                                r.status = dac_pkg::ST_DIV_ZERO;
                            end else begin
                                q = magnitude(acc_img) / magnitude(m);
                                acc_img = (acc_img[31] ^ m[31]) ? (32'd0 - q) : q;
                            end
                        end
                        dac_pkg::OPC_MUL:    acc_img = acc_img * m;
                        dac_pkg::OPC_BR:     npc = opd;
                        dac_pkg::OPC_BRNEG:  if (acc_img[31]) npc = opd;
                        dac_pkg::OPC_BRZERO: if (acc_img == 0) npc = opd;
                        dac_pkg::OPC_HALT: begin
                            halted_img = 1'b1;
                            r.status = dac_pkg::ST_HALTED;
                        end
                        default:    r.status = dac_pkg::ST_BAD_OPC;
                    endcase
                    if (opc != dac_pkg::OPC_HALT) begin
                        pc_img = 7'(npc);
                        if (npc >= MEM) begin
                            pc_img = 7'(MEM);
                            halted_img = 1'b1;
                            if (r.status == dac_pkg::ST_OK) r.status = dac_pkg::ST_PAST_END;
                        end
                    end
                end
            end
        endcase
        r.next_pc = pc_img;
        r.acc_value = acc_img;
    endtask

    // drive one transaction and record what it should produce
    task automatic send(input dac_pkg::op_t op, input logic [6:0] addr,
                        input logic [31:0] data, input logic fixed,
                        input cpu_result_t want);
        cpu_result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_address <= addr;
        s_data_word <= data;
        do @(posedge aclk); while (!s_ready);
        run_machine(op, addr, data, r);
        pending_q.push_back(fixed ? want : r);
    endtask

    always @(posedge aclk) begin
        if (aresetn) m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        cpu_result_t got, exp_r;
        if (aresetn && m_valid && m_ready) begin
            got = {m_peek_word, m_next_pc, m_acc_value, m_out_valid, m_out_word,
                   dac_pkg::status_t'(m_status)};
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transaction %h", got);
            end else begin
                exp_r = pending_q.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: peek %h/%h pc %0d/%0d acc %h/%h ",
                                  "ov %b/%b ow %h/%h st %0d/%0d"},
                                 exp_r.peek_word, got.peek_word, exp_r.next_pc, got.next_pc,
                                 exp_r.acc_value, got.acc_value, exp_r.out_valid, got.out_valid,
                                 exp_r.out_word, got.out_word, exp_r.status, got.status);
                end
            end
        end
    end

    function automatic logic [31:0] pick_data();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'd0;
            4: return $urandom_range(20) - 10;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_instr();
        int codes[12] = '{dac_pkg::OPC_READ, dac_pkg::OPC_WRITE, dac_pkg::OPC_LOAD,
                          dac_pkg::OPC_STORE, dac_pkg::OPC_ADD, dac_pkg::OPC_SUB,
                          dac_pkg::OPC_DIV, dac_pkg::OPC_MUL, dac_pkg::OPC_BR,
                          dac_pkg::OPC_BRNEG, dac_pkg::OPC_BRZERO, dac_pkg::OPC_HALT};
        int c;
        c = codes[$urandom_range(11)];
        if ($urandom_range(9) == 0) return $urandom;
        if (c >= dac_pkg::OPC_BR && c <= dac_pkg::OPC_BRZERO)
            return c * 100 + $urandom_range(15);
        return c * 100 + $urandom_range(16, 99);
    endfunction

    localparam cpu_result_t NOCHK = '0;

    step_row_t directed [26] = '{
        '{dac_pkg::OP_PEEK, 7'd0, 32'd0, 1'b1,
          '{32'd0, 7'd0, 32'd0, 1'b0, 32'd0, dac_pkg::ST_OK}},
        '{dac_pkg::OP_EXEC, 7'd0, 32'd0, 1'b1,
          '{32'd0, 7'd1, 32'd0, 1'b0, 32'd0, dac_pkg::ST_BAD_OPC}},
        '{dac_pkg::OP_PEEK, 7'd127, 32'd0, 1'b1,
          '{32'd0, 7'd1, 32'd0, 1'b0, 32'd0, dac_pkg::ST_OK}},
        '{dac_pkg::OP_LOAD_WORD, 7'd127, 32'h7fffffff, 1'b1,
          '{32'd0, 7'd1, 32'd0, 1'b0, 32'd0, dac_pkg::ST_OK}},
        '{dac_pkg::OP_RESTART, 7'd0, 32'd0, 1'b1,
          '{32'd0, 7'd0, 32'd0, 1'b0, 32'd0, dac_pkg::ST_OK}},
        '{dac_pkg::OP_LOAD_WORD, 7'd50,  32'h80000000,  1'b0, NOCHK},
        '{dac_pkg::OP_LOAD_WORD, 7'd51,  32'hffffffff,  1'b0, NOCHK},
        '{dac_pkg::OP_LOAD_WORD, 7'd0,   32'd2050,      1'b0, NOCHK},
        '{dac_pkg::OP_LOAD_WORD, 7'd1,   32'd3251,      1'b0, NOCHK},
        '{dac_pkg::OP_LOAD_WORD, 7'd2,   32'd3253,      1'b0, NOCHK},
        '{dac_pkg::OP_LOAD_WORD, 7'd3,   32'd1150,      1'b0, NOCHK},
        '{dac_pkg::OP_LOAD_WORD, 7'd4,   32'd4300,      1'b0, NOCHK},
        '{dac_pkg::OP_EXEC,      7'd0,   32'd0,         1'b0, NOCHK},
        '{dac_pkg::OP_EXEC,      7'd0,   32'd0,         1'b0, NOCHK},
        '{dac_pkg::OP_EXEC,      7'd0,   32'd0,         1'b0, NOCHK},
        '{dac_pkg::OP_EXEC,      7'd0,   32'd0,         1'b0, NOCHK},
        '{dac_pkg::OP_EXEC,      7'd0,   32'd0,         1'b0, NOCHK},
        '{dac_pkg::OP_EXEC,      7'd0,   32'd0,         1'b0, NOCHK},
        '{dac_pkg::OP_PEEK,      7'd50,  32'd0,         1'b0, NOCHK},
        '{dac_pkg::OP_RESTART,   7'd0,   32'd0,         1'b0, NOCHK},
        '{dac_pkg::OP_LOAD_WORD, 7'd0,   32'd4099,      1'b0, NOCHK},
        '{dac_pkg::OP_EXEC,      7'd0,   32'd0,         1'b0, NOCHK},
        '{dac_pkg::OP_EXEC,      7'd0,   32'd0,         1'b0, NOCHK},
        '{dac_pkg::OP_EXEC,      7'd0,   32'd0,         1'b0, NOCHK},
        '{dac_pkg::OP_PEEK,      7'd99,  32'd0,         1'b0, NOCHK},
        '{dac_pkg::OP_RESTART,   7'd0,   32'd0,         1'b0, NOCHK}
    };

    initial begin
        int waited, roll;
        for (int i = 0; i < MEM; i++) store_img[i] = 32'd0;
        acc_img = 32'd0;
        pc_img = 7'd0;
        halted_img = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 17;
        recv_idle_pct = 58;
        foreach (directed[i])
            send(directed[i].op, directed[i].addr, directed[i].data,
                 directed[i].fixed, directed[i].want);

        for (int n = 0; n < NRAND; n++) begin
            if (n == NRAND / 3) begin
                send_idle_pct = 58;
                recv_idle_pct = 17;
            end else if (n == 2 * NRAND / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            roll = $urandom_range(99);
            if (halted_img && roll < 60)
                send(dac_pkg::OP_RESTART, 7'($urandom), $urandom, 1'b0, NOCHK);
            else if (roll < 30)
                send(dac_pkg::OP_LOAD_WORD, 7'($urandom_range(15)), pick_instr(),
                     1'b0, NOCHK);
            else if (roll < 45)
                send(dac_pkg::OP_LOAD_WORD, 7'($urandom_range(16, 99)), pick_data(),
                     1'b0, NOCHK);
            else if (roll < 50)
                send(dac_pkg::op_t'(2'($urandom_range(3))), 7'($urandom_range(100, 127)),
                     $urandom, 1'b0, NOCHK);
            else if (roll < 55)
                send(dac_pkg::OP_PEEK, 7'($urandom_range(99)), $urandom, 1'b0, NOCHK);
            else if (roll < 58)
                send(dac_pkg::OP_RESTART, 7'($urandom), $urandom, 1'b0, NOCHK);
            else
                send(dac_pkg::OP_EXEC, 7'($urandom), pick_data(), 1'b0, NOCHK);
        end
        s_valid <= 1'b0;

        waited = 0;
        while (pending_q.size() != 0 && waited < 100000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (60) @(posedge aclk);
        if (mismatches == 0 && pending_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

endmodule

### filelist.f
rtl/dac_pkg.sv
rtl/dac_div.sv
rtl/dac_datapath.sv
rtl/dac_ctrl.sv
rtl/decimal_accumulator_cpu_core.sv
tb/sv/decimal_accumulator_cpu_core_test.sv
